>>> rtl/owts_pkg.sv
// ----------------------------------------------------------------------------
// owts_pkg
// Shared types and constants of the one-wire thermometer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package owts_pkg;

	localparam int SCRATCH_BYTES = 9;
	localparam int CRC_BYTES     = 8;
	localparam int RUN_DEPTH     = 4;

	localparam logic [2:0] OP_RESET     = 3'd0;
	localparam logic [2:0] OP_SAMPLE    = 3'd1;
	localparam logic [2:0] OP_LOOP      = 3'd2;
	localparam logic [2:0] OP_STOP      = 3'd3;
	localparam logic [2:0] OP_SUSPEND   = 3'd4;
	localparam logic [2:0] OP_BUS_DONE  = 3'd5;
	localparam logic [2:0] OP_TIMER     = 3'd6;
	localparam logic [2:0] OP_READ_BYTE = 3'd7;

	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_WRITE    = 3'd1;
	localparam logic [2:0] ACT_READ9    = 3'd2;
	localparam logic [2:0] ACT_RELEASE  = 3'd3;
	localparam logic [2:0] ACT_TIMER    = 3'd4;
	localparam logic [2:0] ACT_TEMP     = 3'd5;
	localparam logic [2:0] ACT_CRC_ERR  = 3'd6;

	localparam logic [7:0] CMD_WRITE_PAD = 8'h4E;
	localparam logic [7:0] CMD_CONVERT   = 8'h44;
	localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
	localparam logic [7:0] ALARM_HIGH    = 8'hC9;
	localparam logic [7:0] ALARM_LOW     = 8'h7D;
	localparam logic [7:0] CRC_POLY      = 8'h8C;

	localparam logic [7:0] RES_BYTE [4] = '{8'h1F, 8'h3F, 8'h5F, 8'h7F};

	typedef struct packed {
		logic [2:0]         action;
		logic [7:0]         wb;
		logic signed [19:0] temp;
	} res_t;

	typedef struct packed {
		logic [2:0]             cnt;
		logic                   busy;
		res_t [RUN_DEPTH-1:0]   ent;
	} run_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
		logic [7:0] r;
		r = c ^ d;
		for (int b = 0; b < 8; b++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/onewire_thermometer_sequencer_top.sv
// ----------------------------------------------------------------------------
// onewire_thermometer_sequencer_top
// Readout sequencer for a one-wire digital thermometer.
//
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    opcode, byte_value
// out       source     out_valid / out_ready  action, write_byte, temperature,
//                                             busy_res, last_of_run
// cfg       sink       cfg_valid / cfg_ready  resolution_select
//
// An item enters the input register and is stepped into the result register
// as soon as that register can load; its first result then shows there.
// A run of k results occupies the result register until all are taken, so
// with out_ready high the rate is one item per cycle for single-result items,
// and a longer run holds off the next item until its last result is taken.
// Reset clears phase, flags, byte count and selects 12-bit resolution; the
// scratchpad is not cleared. With out_ready low one item waits in the input
// register and in_ready drops behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_thermometer_sequencer_top import owts_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [2:0]    opcode,
	input  wire logic [7:0]    byte_value,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         action,
	output logic [7:0]         write_byte,
	output logic signed [19:0] temperature,
	output logic               busy_res,
	output logic               last_of_run,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    resolution_select
);

	logic       valid_s1;
	logic [2:0] opcode_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       advance;
	run_t       run;

	assign advance   = valid_s1 && can_load;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			byte_s1   <= byte_value;
		end
	end

	owts_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_valid),
		.cfg_res (resolution_select),
		.step_en (advance),
		.op      (opcode_s1),
		.bv      (byte_s1),
		.run     (run)
	);

	owts_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.run_in      (run),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action      (action),
		.write_byte  (write_byte),
		.temperature (temperature),
		.busy_res    (busy_res),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

>>> rtl/owts_core.sv
// ----------------------------------------------------------------------------
// owts_core
// Sequencer state, scratchpad and the per-item step logic that builds a run.
// ----------------------------------------------------------------------------
`default_nettype none

module owts_core import owts_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_res,
	input  wire logic       step_en,
	input  wire logic [2:0] op,
	input  wire logic [7:0] bv,
	output run_t            run
);

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_CFG        = 4'd1;
	localparam logic [3:0] PH_CFG_WAIT   = 4'd2;
	localparam logic [3:0] PH_CONV       = 4'd3;
	localparam logic [3:0] PH_CONV_WAIT  = 4'd4;
	localparam logic [3:0] PH_WAIT_START = 4'd5;
	localparam logic [3:0] PH_WAIT       = 4'd6;
	localparam logic [3:0] PH_REQ        = 4'd7;
	localparam logic [3:0] PH_REQ_WAIT   = 4'd8;
	localparam logic [3:0] PH_READ       = 4'd9;
	localparam logic [3:0] PH_READ_WAIT  = 4'd10;
	localparam logic [3:0] PH_PROCESS    = 4'd11;

	localparam logic [3:0] FL_RESET  = 4'b0001;
	localparam logic [3:0] FL_READY  = 4'b0010;
	localparam logic [3:0] FL_LOOP   = 4'b0100;
	localparam logic [3:0] FL_SAMPLE = 4'b1000;

	localparam logic [3:0] NUM_BYTES = 4'(SCRATCH_BYTES);

	logic [3:0] phase_q, phase_d;
	logic [3:0] flags_q, flags_d;
	logic [3:0] br_q, br_d;
	logic [1:0] res_sel_q;
	logic [7:0] store_q [SCRATCH_BYTES];
	logic [7:0] store_d [SCRATCH_BYTES];
	logic [7:0] crc;
	logic [2:0] n;
	logic       busy;
	res_t [RUN_DEPTH-1:0] ent;

	always_comb begin
		crc = 8'h00;
		for (int i = 0; i < CRC_BYTES; i++) begin
			crc = crc8_step(crc, store_q[i]);
		end
	end

	always_comb begin
		phase_d = phase_q;
		flags_d = flags_q;
		br_d    = br_q;
		store_d = store_q;
		n       = 3'd0;
		busy    = 1'b0;
		ent     = '0;

		case (op)
			OP_RESET:   flags_d = flags_q | FL_RESET;
			OP_SAMPLE:  flags_d = flags_q | FL_SAMPLE;
			OP_LOOP:    flags_d = flags_q | FL_LOOP;
			OP_STOP:    flags_d = flags_q & ~(FL_RESET | FL_LOOP | FL_SAMPLE);
			OP_SUSPEND: flags_d = flags_q & FL_RESET;
			OP_BUS_DONE: begin
				case (phase_q)
					PH_CFG_WAIT: begin
						flags_d = (flags_q & ~FL_RESET) | FL_READY;
						phase_d = PH_IDLE;
					end
					PH_CONV_WAIT: phase_d = PH_WAIT_START;
					PH_REQ_WAIT:  phase_d = PH_READ;
					PH_READ_WAIT: phase_d = PH_PROCESS;
					default: ;
				endcase
				if (phase_q != PH_REQ_WAIT) begin
					ent[0] = '{action: ACT_RELEASE, wb: 8'h00, temp: 20'sd0};
					n      = 3'd1;
				end
			end
			OP_TIMER: begin
				if (phase_q == PH_WAIT) begin
					phase_d = PH_REQ;
				end
			end
			default: begin
				if (phase_q == PH_READ_WAIT && br_q < NUM_BYTES) begin
					store_d[br_q] = bv;
					br_d          = br_q + 4'd1;
				end
			end
		endcase

		if (phase_d == PH_PROCESS) begin
			if (crc == store_q[CRC_BYTES]) begin
				ent[n[1:0]] = '{action: ACT_TEMP, wb: 8'h00,
					temp: {store_q[1], store_q[0], 4'h0}};
			end else begin
				ent[n[1:0]] = '{action: ACT_CRC_ERR, wb: 8'h00, temp: 20'sd0};
			end
			n       = n + 3'd1;
			flags_d = flags_d & ~FL_SAMPLE;
			phase_d = PH_IDLE;
		end

		if (phase_d == PH_IDLE || phase_d > PH_PROCESS) begin
			if ((flags_d & FL_RESET) != 4'b0) begin
				phase_d = PH_CFG;
			end else if ((flags_d & (FL_LOOP | FL_SAMPLE)) != 4'b0
					&& (flags_d & FL_READY) != 4'b0) begin
				phase_d = PH_CONV;
			end else begin
				phase_d = PH_IDLE;
			end
		end

		case (phase_d)
			PH_CFG: begin
				if (n == 3'd0) begin
					store_d[0] = CMD_WRITE_PAD;
					store_d[1] = ALARM_HIGH;
					store_d[2] = ALARM_LOW;
					store_d[3] = RES_BYTE[res_sel_q];
					ent[0] = '{action: ACT_WRITE, wb: CMD_WRITE_PAD, temp: 20'sd0};
					ent[1] = '{action: ACT_WRITE, wb: ALARM_HIGH, temp: 20'sd0};
					ent[2] = '{action: ACT_WRITE, wb: ALARM_LOW, temp: 20'sd0};
					ent[3] = '{action: ACT_WRITE, wb: RES_BYTE[res_sel_q], temp: 20'sd0};
					n       = 3'd4;
					flags_d = flags_d & ~FL_READY;
					phase_d = PH_CFG_WAIT;
					busy    = 1'b1;
				end
			end
			PH_CONV: begin
				ent[n[1:0]] = '{action: ACT_WRITE, wb: CMD_CONVERT, temp: 20'sd0};
				n       = n + 3'd1;
				phase_d = PH_CONV_WAIT;
				busy    = 1'b1;
			end
			PH_WAIT_START: begin
				ent[n[1:0]] = '{action: ACT_TIMER, wb: 8'h00, temp: 20'sd0};
				n       = n + 3'd1;
				phase_d = PH_WAIT;
			end
			PH_REQ: begin
				ent[n[1:0]] = '{action: ACT_WRITE, wb: CMD_READ_PAD, temp: 20'sd0};
				n       = n + 3'd1;
				phase_d = PH_REQ_WAIT;
				busy    = 1'b1;
			end
			PH_READ: begin
				ent[n[1:0]] = '{action: ACT_READ9, wb: 8'h00, temp: 20'sd0};
				n       = n + 3'd1;
				br_d    = 4'd0;
				phase_d = PH_READ_WAIT;
				busy    = 1'b1;
			end
			PH_CFG_WAIT, PH_CONV_WAIT, PH_REQ_WAIT, PH_READ_WAIT: busy = 1'b1;
			default: ;
		endcase

		if (n == 3'd0) begin
			ent[0] = '{action: ACT_NONE, wb: 8'h00, temp: 20'sd0};
			n      = 3'd1;
		end
	end

	assign run = '{cnt: n, busy: busy, ent: ent};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			flags_q   <= 4'b0;
			br_q      <= 4'd0;
			res_sel_q <= 2'd3;
		end else begin
			if (step_en) begin
				phase_q <= phase_d;
				flags_q <= flags_d;
				br_q    <= br_d;
			end
			if (cfg_we) begin
				res_sel_q <= cfg_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			store_q <= store_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/owts_outbuf.sv
// ----------------------------------------------------------------------------
// owts_outbuf
// Result register that holds one run of up to four results and drains it.
// ----------------------------------------------------------------------------
`default_nettype none

module owts_outbuf import owts_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire run_t          run_in,
	output logic               can_load,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         action,
	output logic [7:0]         write_byte,
	output logic signed [19:0] temperature,
	output logic               busy_res,
	output logic               last_of_run
);

	res_t [RUN_DEPTH-1:0] ent_q;
	logic [2:0]           cnt_q;
	logic                 busy_q;
	logic [1:0]           idx_q;
	logic                 valid_q;
	logic [2:0]           last_idx;
	logic                 last;

	assign last_idx = cnt_q - 3'd1;
	assign last     = ({1'b0, idx_q} == last_idx);
	assign can_load = !valid_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
			cnt_q   <= 3'd1;
			busy_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
			cnt_q   <= run_in.cnt;
			busy_q  <= run_in.busy;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= run_in.ent;
		end
	end

	assign out_valid   = valid_q;
	assign action      = ent_q[idx_q].action;
	assign write_byte  = ent_q[idx_q].wb;
	assign temperature = ent_q[idx_q].temp;
	assign busy_res    = busy_q;
	assign last_of_run = last;

endmodule

`default_nettype wire

>>> rtl/owts_checker.sv
// ----------------------------------------------------------------------------
// owts_checker
// Port-level checks of the sequencer's result runs.
// ----------------------------------------------------------------------------
`default_nettype none

module owts_checker import owts_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [2:0]         action,
	input wire logic [7:0]         write_byte,
	input wire logic signed [19:0] temperature,
	input wire logic               busy_res,
	input wire logic               last_of_run
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action)
			&& $stable(write_byte) && $stable(temperature))
		else $error("stalled result changed");

	a_wb_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_WRITE |-> write_byte == 8'h00)
		else $error("write byte set on a non-write result");

	a_temp_only_on_temp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_TEMP |-> temperature == 20'sd0)
		else $error("temperature set on a non-temperature result");

	a_run_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a result run");

	a_run_busy_same: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> busy_res == $past(busy_res))
		else $error("busy changed inside a result run");

endmodule

bind onewire_thermometer_sequencer_top owts_checker u_owts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.action      (action),
	.write_byte  (write_byte),
	.temperature (temperature),
	.busy_res    (busy_res),
	.last_of_run (last_of_run)
);

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the thermometer sequencer with event items, first from a short table
// that walks a configuration write, a full conversion and read, a short read
// with a bad checksum and a reset raised during the read, then with random
// event streams that mostly follow a well-formed conversion cycle. Every
// result is compared field by field against an in-bench model of the
// sequence; the sender bursts and gaps, the receiver stalls, and the
// resolution register is rewritten between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import owts_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE, P_CFG, P_CFG_WAIT, P_CONV, P_CONV_WAIT, P_WAIT_START,
		P_WAIT, P_REQ, P_REQ_WAIT, P_READ, P_READ_WAIT, P_PROCESS
	} seq_phase_e;

	typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_PERIODIC} sink_mode_e;

	typedef struct packed {
		logic [2:0]         action;
		logic [7:0]         wb;
		logic signed [19:0] temp;
		logic               busy;
		logic               last;
	} bus_result_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [7:0]         bv;
		logic               use_crc;
		logic [2:0]         pos;
		logic [2:0]         act;
		logic [7:0]         wb;
		logic signed [19:0] temp;
	} directed_row_t;

	typedef logic [7:0] pad_t [SCRATCH_BYTES];

	localparam logic [3:0] FL_RESET  = 4'h1;
	localparam logic [3:0] FL_READY  = 4'h2;
	localparam logic [3:0] FL_LOOP   = 4'h4;
	localparam logic [3:0] FL_SAMPLE = 4'h8;

	localparam logic [2:0] NO_CHECK = 3'd7;
	localparam int N_DIRECTED = 29;
	localparam int N_RANDOM_PHASE = 100;

	localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{OP_LOOP,      8'h00, 1'b0, 3'd0,     ACT_NONE,    8'h00,         20'sd0},
		'{OP_TIMER,     8'h00, 1'b0, 3'd0,     ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'hFF, 1'b0, 3'd0,     ACT_NONE,    8'h00,         20'sd0},
		'{OP_BUS_DONE,  8'h00, 1'b0, 3'd0,     ACT_RELEASE, 8'h00,         20'sd0},
		'{OP_RESET,     8'h00, 1'b0, 3'd3,     ACT_WRITE,   8'h1F,         20'sd0},
		'{OP_SAMPLE,    8'h00, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_RESET,     8'h00, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_BUS_DONE,  8'h00, 1'b0, 3'd1,     ACT_WRITE,   CMD_CONVERT,   20'sd0},
		'{OP_BUS_DONE,  8'h00, 1'b0, 3'd1,     ACT_TIMER,   8'h00,         20'sd0},
		'{OP_TIMER,     8'h00, 1'b0, 3'd0,     ACT_WRITE,   CMD_READ_PAD,  20'sd0},
		'{OP_BUS_DONE,  8'h00, 1'b0, 3'd0,     ACT_READ9,   8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'hFF, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'h7F, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'h5A, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'hA5, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'h00, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'hFF, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'h0F, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'hF0, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'h00, 1'b1, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_BUS_DONE,  8'h00, 1'b0, 3'd1,     ACT_TEMP,    8'h00,         20'sd524272},
		'{OP_BUS_DONE,  8'h00, 1'b0, 3'd1,     ACT_TIMER,   8'h00,         20'sd0},
		'{OP_STOP,      8'h00, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_TIMER,     8'h00, 1'b0, 3'd0,     ACT_WRITE,   CMD_READ_PAD,  20'sd0},
		'{OP_RESET,     8'h00, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_BUS_DONE,  8'h00, 1'b0, 3'd0,     ACT_READ9,   8'h00,         20'sd0},
		'{OP_READ_BYTE, 8'h00, 1'b0, NO_CHECK, ACT_NONE,    8'h00,         20'sd0},
		'{OP_BUS_DONE,  8'h00, 1'b0, 3'd1,     ACT_CRC_ERR, 8'h00,         20'sd0},
		'{OP_SUSPEND,   8'h00, 1'b0, 3'd3,     ACT_WRITE,   8'h1F,         20'sd0}
	};

	localparam logic [1:0] RES_SETTINGS [4] = '{2'd3, 2'd1, 2'd2, 2'd0};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         opcode;
	logic [7:0]         byte_value;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         action;
	logic [7:0]         write_byte;
	logic signed [19:0] temperature;
	logic               busy_res;
	logic               last_of_run;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         resolution_select;

	seq_phase_e  phase = P_IDLE;
	logic [3:0]  flags = 4'h0;
	pad_t        scratch = '{default: 8'h00};
	logic [8:0]  pad_written = 9'h000;
	int          byte_count = 0;
	logic [1:0]  res_sel = 2'd3;

	bus_result_t run_buf [RUN_DEPTH];
	int          run_len;
	bus_result_t expected_actions [$];
	pad_t        next_frame = '{default: 8'h00};
	bit          failed = 1'b0;

	sink_mode_e  ready_mode = SINK_OPEN;
	int          ready_hold = 0;
	int          ready_tick = 0;

	onewire_thermometer_sequencer_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.opcode            (opcode),
		.byte_value        (byte_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.action            (action),
		.write_byte        (write_byte),
		.temperature       (temperature),
		.busy_res          (busy_res),
		.last_of_run       (last_of_run),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.resolution_select (resolution_select)
	);

	always begin
		#5ns clk = 1'b1;
		#5ns clk = 1'b0;
	end

	function automatic logic [7:0] dallas_crc(input pad_t b);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < 8; i++) begin
			c ^= b[i];
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
		end
		return c;
	endfunction

	function automatic void put_result(input logic [2:0] act, input logic [7:0] wb,
			input logic [19:0] temp);
		if (run_len < RUN_DEPTH) begin
			run_buf[run_len] = '{action: act, wb: wb, temp: temp, busy: 1'b0, last: 1'b0};
			run_len++;
		end
	endfunction

	function automatic void predict_sequencer_step(input logic [2:0] op, input logic [7:0] bv);
		logic busy;
		logic again;
		logic [15:0] raw;
		run_len = 0;
		busy = 1'b0;
		case (op)
			OP_RESET:   flags |= FL_RESET;
			OP_SAMPLE:  flags |= FL_SAMPLE;
			OP_LOOP:    flags |= FL_LOOP;
			OP_STOP:    flags &= ~(FL_RESET | FL_LOOP | FL_SAMPLE);
			OP_SUSPEND: flags &= FL_RESET;
			OP_BUS_DONE: begin
				if (phase == P_REQ_WAIT) begin
					phase = P_READ;
				end else begin
					if (phase == P_CFG_WAIT) begin
						flags = (flags & ~FL_RESET) | FL_READY;
						phase = P_IDLE;
					end else if (phase == P_CONV_WAIT) begin
						phase = P_WAIT_START;
					end else if (phase == P_READ_WAIT) begin
						phase = P_PROCESS;
					end
					put_result(ACT_RELEASE, 8'h00, 20'h0);
				end
			end
			OP_TIMER: if (phase == P_WAIT) phase = P_REQ;
			default: begin
				if (phase == P_READ_WAIT && byte_count < SCRATCH_BYTES) begin
					scratch[byte_count] = bv;
					pad_written[byte_count] = 1'b1;
					byte_count++;
				end
			end
		endcase

		do begin
			busy = 1'b0;
			again = 1'b0;
			case (phase)
				P_IDLE: begin
					if ((flags & FL_RESET) != 0) begin
						phase = P_CFG;
						again = 1'b1;
					end else if ((flags & (FL_LOOP | FL_SAMPLE)) != 0
							&& (flags & FL_READY) != 0) begin
						phase = P_CONV;
						again = 1'b1;
					end
				end
				P_CFG: begin
					// hold the config bytes for the next item if this one emitted anything
					if (run_len == 0) begin
						phase = P_CFG_WAIT;
						flags &= ~FL_READY;
						scratch[0] = CMD_WRITE_PAD;
						scratch[1] = ALARM_HIGH;
						scratch[2] = ALARM_LOW;
						scratch[3] = RES_BYTE[res_sel];
						pad_written[3:0] = 4'hF;
						for (int i = 0; i < 4; i++) put_result(ACT_WRITE, scratch[i], 20'h0);
						busy = 1'b1;
					end
				end
				P_CONV: begin
					phase = P_CONV_WAIT;
					put_result(ACT_WRITE, CMD_CONVERT, 20'h0);
					busy = 1'b1;
				end
				P_WAIT_START: begin
					phase = P_WAIT;
					put_result(ACT_TIMER, 8'h00, 20'h0);
				end
				P_WAIT: ;
				P_REQ: begin
					phase = P_REQ_WAIT;
					put_result(ACT_WRITE, CMD_READ_PAD, 20'h0);
					busy = 1'b1;
				end
				P_READ: begin
					phase = P_READ_WAIT;
					byte_count = 0;
					put_result(ACT_READ9, 8'h00, 20'h0);
					busy = 1'b1;
				end
				P_CFG_WAIT, P_CONV_WAIT, P_REQ_WAIT, P_READ_WAIT: busy = 1'b1;
				P_PROCESS: begin
					if (dallas_crc(scratch) == scratch[8]) begin
						raw = {scratch[1], scratch[0]};
						put_result(ACT_TEMP, 8'h00, {raw, 4'h0});
					end else begin
						put_result(ACT_CRC_ERR, 8'h00, 20'h0);
					end
					phase = P_IDLE;
					flags &= ~FL_SAMPLE;
					again = 1'b1;
				end
				default: begin
					phase = P_IDLE;
					again = 1'b1;
				end
			endcase
		end while (again);

		if (run_len == 0) put_result(ACT_NONE, 8'h00, 20'h0);
		for (int k = 0; k < run_len; k++) begin
			run_buf[k].busy = busy;
			run_buf[k].last = (k == run_len - 1);
			expected_actions.push_back(run_buf[k]);
		end
	endfunction

	function automatic void build_frame();
		logic [15:0] raw;
		case ($urandom_range(0, 5))
			0: raw = 16'h7FFF;
			1: raw = 16'h8000;
			2: raw = 16'(-55 * 16);
			3: raw = 16'(125 * 16);
			default: raw = 16'($urandom);
		endcase
		next_frame[0] = raw[7:0];
		next_frame[1] = raw[15:8];
		for (int i = 2; i < 8; i++) next_frame[i] = 8'($urandom);
		next_frame[8] = dallas_crc(next_frame);
		if ($urandom_range(0, 6) == 0) next_frame[8] ^= 8'($urandom_range(1, 255));
	endfunction

	// follow the conversion cycle most of the time, scatter noise otherwise
	function automatic void pick_item(output logic [2:0] op, output logic [7:0] bv);
		int r;
		r = $urandom_range(0, 99);
		op = 3'($urandom_range(0, 7));
		bv = 8'($urandom);
		if (r >= 12) begin
			case (phase)
				P_IDLE: begin
					if ((flags & FL_READY) == 0 || r < 20) op = OP_RESET;
					else op = (r < 80) ? OP_SAMPLE : OP_LOOP;
				end
				P_CFG: op = OP_SAMPLE;
				P_CFG_WAIT, P_CONV_WAIT, P_REQ_WAIT: op = OP_BUS_DONE;
				P_WAIT: op = (r < 20) ? OP_STOP : OP_TIMER;
				P_READ_WAIT: begin
					if (byte_count == 0) build_frame();
					if (byte_count < SCRATCH_BYTES && r >= 16) begin
						op = OP_READ_BYTE;
						bv = next_frame[byte_count];
					end else begin
						op = OP_BUS_DONE;
					end
				end
				default: ;
			endcase
		end
		// never let a read finish over scratchpad entries that were never written
		if (op == OP_BUS_DONE && phase == P_READ_WAIT && pad_written != 9'h1FF) begin
			op = OP_READ_BYTE;
			if (byte_count < SCRATCH_BYTES) bv = next_frame[byte_count];
		end
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [7:0] bv);
		in_valid <= 1'b1;
		opcode <= op;
		byte_value <= bv;
		do @(posedge clk); while (!in_ready);
		predict_sequencer_step(op, bv);
	endtask

	task automatic idle_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_actions.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_resolution(input logic [1:0] sel);
		cfg_valid <= 1'b1;
		resolution_select <= sel;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		res_sel = sel;
	endtask

	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_mode <= sink_mode_e'($urandom_range(0, 3));
			ready_hold <= $urandom_range(16, 160);
		end else begin
			ready_hold <= ready_hold - 1;
		end
		case (ready_mode)
			SINK_OPEN:     out_ready <= 1'b1;
			SINK_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
			SINK_SLOW:     out_ready <= ($urandom_range(0, 5) == 0);
			SINK_PERIODIC: out_ready <= (ready_tick % 3 == 0);
		endcase
		ready_tick <= ready_tick + 1;
	end

	always @(posedge clk) begin
		bus_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_actions.size() == 0) begin
				$error("unexpected result: action %0d write_byte %0h", action, write_byte);
				failed = 1'b1;
			end else begin
				want = expected_actions.pop_front();
				if (action !== want.action) begin
					$error("action: expected %0d, got %0d", want.action, action);
					failed = 1'b1;
				end
				if (write_byte !== want.wb) begin
					$error("write_byte: expected %0h, got %0h", want.wb, write_byte);
					failed = 1'b1;
				end
				if (temperature !== want.temp) begin
					$error("temperature: expected %0d, got %0d", want.temp, temperature);
					failed = 1'b1;
				end
				if (busy_res !== want.busy) begin
					$error("busy_res: expected %0d, got %0d", want.busy, busy_res);
					failed = 1'b1;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		directed_row_t row;
		bus_result_t fixed;
		logic [2:0] op;
		logic [7:0] bv;
		int idx;
		int burst;
		int sent;
		bit counted;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_RESET;
		byte_value <= 8'h00;
		cfg_valid <= 1'b0;
		resolution_select <= 2'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_resolution(2'd0);
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED_ROWS[i];
			bv = row.use_crc ? dallas_crc(scratch) : row.bv;
			if ($urandom_range(0, 3) == 0) idle_input($urandom_range(1, 4));
			send_item(row.op, bv);
			if (row.pos != NO_CHECK) begin
				idx = expected_actions.size() - run_len + int'(row.pos);
				fixed = expected_actions[idx];
				fixed.action = row.act;
				fixed.wb = row.wb;
				fixed.temp = row.temp;
				expected_actions[idx] = fixed;
			end
		end
		drain_results();

		burst = 0;
		foreach (RES_SETTINGS[s]) begin
			write_resolution(RES_SETTINGS[s]);
			sent = 0;
			while (sent < N_RANDOM_PHASE) begin
				if (burst == 0) begin
					idle_input($urandom_range(1, 8));
					burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 12);
				end
				pick_item(op, bv);
				// skip read bytes outside a read and timer events outside the wait in the count
				counted = !((op == OP_READ_BYTE && phase != P_READ_WAIT)
					|| (op == OP_TIMER && phase != P_WAIT));
				send_item(op, bv);
				if (counted) sent++;
				burst--;
				if ($urandom_range(0, 59) == 0) drain_results();
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (failed || expected_actions.size() != 0) begin
			$display("Some tests failed");
		end else begin
			$display("All tests passed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/owts_pkg.sv
rtl/owts_core.sv
rtl/owts_outbuf.sv
rtl/onewire_thermometer_sequencer_top.sv
rtl/owts_checker.sv
verif/tb_top.sv
